// ===== rtl/uniaxial_anisotropy_field_top_macros.svh =====
// ----------------------------------------------------------------------------
// uniaxial_anisotropy_field_top_macros.svh
// Assertion shorthands for the anisotropy field block; all sampled on clk,
// disabled during rst.
// ----------------------------------------------------------------------------
`ifndef UNIAXIAL_ANISOTROPY_FIELD_TOP_MACROS_SVH
`define UNIAXIAL_ANISOTROPY_FIELD_TOP_MACROS_SVH

// consequent must hold in the same cycle
`define UAF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the following cycle
`define UAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/uaf_pkg.sv =====
// ----------------------------------------------------------------------------
// uaf_pkg
// Shared constants and register codes for the uniaxial anisotropy field block.
// ----------------------------------------------------------------------------
package uaf_pkg;

  // default fraction bits of the magnetization / d-power format
  localparam int MAG_FRAC_BITS_DEF = 15;
  // easy axis is Q1.15
  localparam int AXIS_FRAC = 15;
  // 1/mu0 = INV_MU0_Q / 2^INV_MU0_SHIFT
  localparam int INV_MU0_SHIFT = 12;
  localparam logic [31:0] INV_MU0_Q = 32'd3259493235;

  // multi-word product register: four 32-bit limbs
  localparam int LIMB_W = 32;
  localparam int WIDE_W = 128;

  // source_mode bits
  localparam int MODE_NODE_MS  = 0;
  localparam int MODE_NODE_KU1 = 1;
  localparam int MODE_NODE_KU2 = 2;
  localparam int MODE_ENERGY   = 3;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_AXIS_X      = 3'd1,
    REG_AXIS_Y      = 3'd2,
    REG_AXIS_Z      = 3'd3,
    REG_DEFAULT_MS  = 3'd4,
    REG_DEFAULT_KU  = 3'd5,
    REG_DEFAULT_KU2 = 3'd6,
    REG_SOURCE_MODE = 3'd7
  } cfg_reg_t;

endpackage

// ===== rtl/uniaxial_anisotropy_field_top.sv =====
// ----------------------------------------------------------------------------
// uniaxial_anisotropy_field_top
// Uniaxial (Ku1/Ku2) anisotropy field and energy, one mesh node per word.
// ----------------------------------------------------------------------------
// One node is taken at a time; s_axis_tready is high only while the sequencer
// is idle. A magnetic, enabled node forms its dot product and powers of d,
// then its energy product, rounding and accumulation when energy is to be
// added, then each of the three field components in turn. The work is
// dominated by the bit-serial divider by Ms, which runs MAG_FRAC_BITS+82
// steps for each field component, plus the limb-serial products on the one
// shared 33x33 multiplier. A component with zero Ms, a zero numerator or a
// zero axis entry skips the products and the divider and gives a zero field.
// A disabled or non-magnetic node goes from acceptance straight to the
// output state. A finished node waits in the output state while the result
// register is full and not taken.
// The result register lets the next node be taken while a result waits.
// The energy total is reported with every result and cleared after the
// result marked last.
`include "uniaxial_anisotropy_field_top_macros.svh"

module uniaxial_anisotropy_field_top
  import uaf_pkg::*;
#(
  parameter int MAG_FRAC_BITS = MAG_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input node words
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mag_x, mag_y, mag_z, node_ms, node_ku, node_ku2, node_volume
  input  logic [167:0] s_axis_tdata,
  // is_magnetic
  input  logic [0:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  // result words
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // field_x, field_y, field_z, energy_total
  output logic [159:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int F    = MAG_FRAC_BITS;
  localparam int DW   = F + 1;                          // |d|, d^2..d^4
  localparam int NW   = F + 37;                         // field numerator
  localparam int EW   = F + 34;                         // node energy density
  localparam int DIVW = F + 82;                         // dividend bits
  localparam int FSH  = F + AXIS_FRAC + INV_MU0_SHIFT;  // field round shift
  localparam int VW   = DIVW + 1 - FSH;
  localparam int EPW  = F + 65;                         // |e| * volume bits
  localparam int EVW  = EPW + 1 - F;
  localparam int DCW  = $clog2(DIVW + 1);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DOT   = 15'b000000000000010,
    S_DM    = 15'b000000000000100,
    S_POW   = 15'b000000000001000,
    S_KU    = 15'b000000000010000,
    S_EPREP = 15'b000000000100000,
    S_EMUL  = 15'b000000001000000,
    S_ERND  = 15'b000000010000000,
    S_EACC  = 15'b000000100000000,
    S_FPREP = 15'b000001000000000,
    S_FMUL1 = 15'b000010000000000,
    S_FMUL2 = 15'b000100000000000,
    S_FDIV  = 15'b001000000000000,
    S_FRND  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  // configuration registers
  logic               enable_r;
  logic signed [15:0] axis_x_r, axis_y_r, axis_z_r;
  logic [23:0]        default_ms_r;
  logic signed [31:0] default_ku_r, default_ku2_r;
  logic [3:0]         source_mode_r;

  // control
  state_t          state;
  logic [2:0]      cnt;
  logic [1:0]      ci;
  logic [DCW-1:0]  divcnt;
  logic signed [63:0] energy_acc;

  // node operands
  logic signed [15:0] mag_x_r, mag_y_r, mag_z_r;
  logic [23:0]        ms_r;
  logic signed [31:0] ku1_r, ku2_r;
  logic [31:0]        vol_r;
  logic               last_r;

  // datapath
  logic signed [33:0]   raw;
  logic                 neg_d;
  logic [DW-1:0]        dm, d2, d3, d4;
  logic signed [NW-1:0] num;
  logic signed [EW-1:0] e_dens;
  logic [WIDE_W-1:0]    wa;
  logic [31:0]          carry;
  logic [23:0]          rem;
  logic [62:0]          em;
  logic [31:0]          fld [3];

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // combinational helpers
  logic                 in_acc, out_load, skip_comp, neg_f, e_go;
  logic signed [15:0]   axis_sel;
  logic [15:0]          axis_mag;
  logic signed [DW:0]   d_s, dc_s;
  logic [1:0]           wi;
  logic [63:0]          limb_sum;
  logic [63:0]          pow_sum;
  logic [DW-1:0]        pow_rnd;
  logic [33:0]          rmag, rr, one_f;
  logic [34:0]          rsum;
  logic signed [NW-1:0] nmag;
  logic signed [EW-1:0] emag;
  logic [24:0]          div_t;
  logic                 div_ge;
  logic [DIVW:0]        q_sum;
  logic [VW-1:0]        fv, fcap;
  logic [31:0]          fmag;
  logic [EPW:0]         e_sum;
  logic [EVW-1:0]       ev;
  logic signed [63:0]   node_e;
  logic signed [64:0]   acc_sum;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_r      <= 1'b0;
      axis_x_r      <= 16'sd0;
      axis_y_r      <= 16'sd0;
      axis_z_r      <= 16'sd32767;
      default_ms_r  <= 24'd0;
      default_ku_r  <= 32'sd0;
      default_ku2_r <= 32'sd0;
      source_mode_r <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:      enable_r      <= cfg_data[0];
        REG_AXIS_X:      axis_x_r      <= cfg_data[15:0];
        REG_AXIS_Y:      axis_y_r      <= cfg_data[15:0];
        REG_AXIS_Z:      axis_z_r      <= cfg_data[15:0];
        REG_DEFAULT_MS:  default_ms_r  <= cfg_data[23:0];
        REG_DEFAULT_KU:  default_ku_r  <= cfg_data;
        REG_DEFAULT_KU2: default_ku2_r <= cfg_data;
        REG_SOURCE_MODE: source_mode_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // signed d and d^3 from magnitude and sign
  assign d_s  = neg_d ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
  assign dc_s = neg_d ? -$signed({1'b0, d3}) : $signed({1'b0, d3});

  // easy-axis component for the field component in work
  always_comb begin
    unique case (ci)
      2'd0:    axis_sel = axis_x_r;
      2'd1:    axis_sel = axis_y_r;
      2'd2:    axis_sel = axis_z_r;
      default: axis_sel = axis_z_r;
    endcase
  end
  assign axis_mag  = axis_sel[15] ? 16'(-axis_sel) : axis_sel;
  assign skip_comp = (ms_r == 24'd0) || (num == '0) || (axis_sel == 16'sd0);
  assign neg_f     = num[NW-1] ^ axis_sel[15];
  assign e_go      = source_mode_r[MODE_ENERGY] && (e_dens != '0) && (vol_r != 32'd0);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DOT: begin
        unique case (cnt[1:0])
          2'd0: begin mul_a = 33'(mag_x_r); mul_b = 33'(axis_x_r); end
          2'd1: begin mul_a = 33'(mag_y_r); mul_b = 33'(axis_y_r); end
          2'd2: begin mul_a = 33'(mag_z_r); mul_b = 33'(axis_z_r); end
          default: ;
        endcase
      end
      S_POW: begin
        if (cnt == 3'd0) begin
          mul_a = 33'(dm); mul_b = 33'(dm);
        end else if (cnt == 3'd2) begin
          mul_a = 33'(d2); mul_b = 33'(dm);
        end else if (cnt == 3'd3) begin
          mul_a = 33'(d2); mul_b = 33'(d2);
        end
      end
      S_KU: begin
        if (cnt == 3'd0) begin
          mul_a = 33'(ku1_r); mul_b = 33'(d_s);
        end else if (cnt == 3'd1) begin
          mul_a = 33'(ku2_r); mul_b = 33'(dc_s);
        end else if (cnt == 3'd2) begin
          mul_a = 33'(ku1_r); mul_b = 33'(d2);
        end else if (cnt == 3'd3) begin
          mul_a = 33'(ku2_r); mul_b = 33'(d4);
        end
      end
      S_EMUL: begin
        mul_a = 33'(wa[LIMB_W*cnt[1:0] +: LIMB_W]);
        mul_b = 33'(vol_r);
      end
      S_FMUL1: begin
        mul_a = 33'(wa[LIMB_W*cnt[1:0] +: LIMB_W]);
        mul_b = 33'(axis_mag);
      end
      S_FMUL2: begin
        mul_a = 33'(wa[LIMB_W*cnt[1:0] +: LIMB_W]);
        mul_b = 33'(INV_MU0_Q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // limb step: limb (cnt-1) gets product plus carry
  assign wi       = 2'(cnt - 3'd1);
  assign limb_sum = prod[63:0] + 64'(carry);

  // rounded power of d
  assign pow_sum = prod[63:0] + (64'd1 << (F - 1));
  assign pow_rnd = pow_sum[F +: DW];

  // |d| from the dot product, clamped to 1.0
  assign rmag  = raw[33] ? 34'(-raw) : 34'(raw);
  assign rsum  = 35'(rmag) + (35'd1 << (AXIS_FRAC - 1));
  assign rr    = 34'(rsum >> AXIS_FRAC);
  assign one_f = 34'd1 << F;

  assign nmag = num[NW-1] ? -num : num;
  assign emag = e_dens[EW-1] ? -e_dens : e_dens;

  // restoring division step
  assign div_t  = {rem, wa[DIVW-1]};
  assign div_ge = div_t >= {1'b0, ms_r};

  // field rounding and saturation
  assign q_sum = {1'b0, wa[DIVW-1:0]} + ((DIVW+1)'(1) << (FSH - 1));
  assign fv    = q_sum[DIVW:FSH];
  assign fcap  = neg_f ? (VW'(1) << 31) : ((VW'(1) << 31) - VW'(1));
  assign fmag  = (fv > fcap) ? fcap[31:0] : fv[31:0];

  // node energy rounding and saturation
  assign e_sum   = {1'b0, wa[EPW-1:0]} + ((EPW+1)'(1) << (F - 1));
  assign ev      = e_sum[EPW:F];
  assign node_e  = e_dens[EW-1] ? $signed({1'b0, em}) : -$signed({1'b0, em});
  assign acc_sum = {energy_acc[63], energy_acc} + {node_e[63], node_e};

  // sequencer and reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= 3'd0;
      ci            <= 2'd0;
      divcnt        <= '0;
      energy_acc    <= 64'sd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= 3'd0;
          if (in_acc) begin
            state <= (enable_r && s_axis_tuser[0]) ? S_DOT : S_OUT;
          end
        end
        S_DOT: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) state <= S_DM;
        end
        S_DM: begin
          cnt   <= 3'd0;
          state <= S_POW;
        end
        S_POW: begin
          if (cnt == 3'd4) begin
            cnt   <= 3'd0;
            state <= S_KU;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_KU: begin
          if (cnt == 3'd4) begin
            cnt   <= 3'd0;
            state <= S_EPREP;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_EPREP: begin
          ci    <= 2'd0;
          cnt   <= 3'd0;
          state <= e_go ? S_EMUL : S_FPREP;
        end
        S_EMUL: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) state <= S_ERND;
        end
        S_ERND: state <= S_EACC;
        S_EACC: begin
          if (acc_sum[64] != acc_sum[63]) begin
            energy_acc <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            energy_acc <= acc_sum[63:0];
          end
          state <= S_FPREP;
        end
        S_FPREP: begin
          cnt <= 3'd0;
          if (!skip_comp) begin
            state <= S_FMUL1;
          end else if (ci == 2'd2) begin
            state <= S_OUT;
          end else begin
            ci <= ci + 2'd1;
          end
        end
        S_FMUL1: begin
          if (cnt == 3'd4) begin
            cnt   <= 3'd0;
            state <= S_FMUL2;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_FMUL2: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            divcnt <= '0;
            state  <= S_FDIV;
          end
        end
        S_FDIV: begin
          divcnt <= divcnt + DCW'(1);
          if (divcnt == DCW'(DIVW - 1)) state <= S_FRND;
        end
        S_FRND: begin
          if (ci == 2'd2) begin
            state <= S_OUT;
          end else begin
            ci    <= ci + 2'd1;
            state <= S_FPREP;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
            if (last_r) energy_acc <= 64'sd0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          mag_x_r <= s_axis_tdata[15:0];
          mag_y_r <= s_axis_tdata[31:16];
          mag_z_r <= s_axis_tdata[47:32];
          ms_r    <= source_mode_r[MODE_NODE_MS]  ? s_axis_tdata[71:48]   : default_ms_r;
          ku1_r   <= source_mode_r[MODE_NODE_KU1] ? s_axis_tdata[103:72]  : default_ku_r;
          ku2_r   <= source_mode_r[MODE_NODE_KU2] ? s_axis_tdata[135:104] : default_ku2_r;
          vol_r   <= s_axis_tdata[167:136];
          last_r  <= s_axis_tlast;
          raw     <= 34'sd0;
          fld[0]  <= 32'd0;
          fld[1]  <= 32'd0;
          fld[2]  <= 32'd0;
        end
      end
      S_DOT: begin
        if (cnt != 3'd0) raw <= raw + 34'(prod);
      end
      S_DM: begin
        neg_d <= raw[33];
        dm    <= (rr > one_f) ? DW'(one_f) : DW'(rr);
      end
      S_POW: begin
        if (cnt == 3'd1) begin
          d2 <= pow_rnd;
        end else if (cnt == 3'd3) begin
          d3 <= pow_rnd;
        end else if (cnt == 3'd4) begin
          d4 <= pow_rnd;
        end
      end
      S_KU: begin
        if (cnt == 3'd1) begin
          num <= NW'(prod <<< 1);
        end else if (cnt == 3'd2) begin
          num <= num + NW'(prod <<< 2);
        end else if (cnt == 3'd3) begin
          e_dens <= EW'(prod);
        end else if (cnt == 3'd4) begin
          e_dens <= e_dens + EW'(prod);
        end
      end
      S_EPREP: begin
        wa    <= WIDE_W'($unsigned(emag));
        carry <= 32'd0;
      end
      S_EMUL, S_FMUL1, S_FMUL2: begin
        if (cnt == 3'd0) begin
          carry <= 32'd0;
        end else begin
          wa[LIMB_W*wi +: LIMB_W] <= limb_sum[31:0];
          carry                   <= limb_sum[63:32];
        end
      end
      S_ERND: begin
        em <= (ev > EVW'({1'b0, {63{1'b1}}})) ? {63{1'b1}} : ev[62:0];
      end
      S_FPREP: begin
        wa    <= WIDE_W'($unsigned(nmag));
        carry <= 32'd0;
        if (skip_comp) fld[ci] <= 32'd0;
      end
      S_FDIV: begin
        rem <= div_ge ? 24'(div_t - {1'b0, ms_r}) : div_t[23:0];
        wa  <= {wa[WIDE_W-2:0], div_ge};
      end
      S_FRND: begin
        fld[ci] <= neg_f ? -fmag : fmag;
      end
      default: ;
    endcase
    if (state == S_FMUL2 && cnt == 3'd4) rem <= 24'd0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {energy_acc, fld[2], fld[1], fld[0]};
      m_axis_tlast <= last_r;
    end
  end

  // checks
  `UAF_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready, "accepted a word while busy")
  `UAF_ASSERT_SAME(a_rem_below_ms, state == S_FDIV, rem < ms_r, "divider remainder not below Ms")
  `UAF_ASSERT_NEXT(a_clear_after_last, out_load && last_r, energy_acc == 64'sd0, "energy not cleared")

endmodule
